// File: rtl/core/esb_pkg.sv
`timescale 1ns / 1ps

package esb_pkg;

    localparam int CMD_W       = 2;
    localparam int INDEX_W     = 21;
    localparam int BYTE_W      = 8;
    localparam int ELEV_W      = 16;
    localparam int FRAC_W      = 24;
    localparam int W_W         = FRAC_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 8;

    // unit weight, 1.0 in 1.FRAC_W
    localparam logic [W_W-1:0] W_ONE = {1'b1, {FRAC_W{1'b0}}};

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD     = 2'd0,
        CMD_NEAREST  = 2'd1,
        CMD_BILINEAR = 2'd2
    } esb_cmd_t;

    typedef enum logic [1:0] {
        PH_READ00,
        PH_READ01,
        PH_READ10,
        PH_READ11
    } esb_phase_t;

    typedef struct packed {
        esb_cmd_t            op;
        logic [ELEV_W-1:0]   wdata;
        logic [FRAC_W-1:0]   dy;
        logic [FRAC_W-1:0]   dx;
    } esb_job_t;

endpackage

// File: rtl/core/esb_front.sv
`timescale 1ns / 1ps

module esb_front import esb_pkg::*; #(
    parameter int GRID_SIZE = 1201,
    localparam int ADDR_W = $clog2(GRID_SIZE * GRID_SIZE)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CMD_W-1:0]     s_cmd,
    input  logic [INDEX_W-1:0]   s_sample_index,
    input  logic [BYTE_W-1:0]    s_sample_high_byte,
    input  logic [BYTE_W-1:0]    s_sample_low_byte,
    input  logic [FRAC_W-1:0]    s_lat_fraction,
    input  logic [FRAC_W-1:0]    s_lon_fraction,
    output logic                 q_push,
    output esb_job_t             q_job,
    output logic [ADDR_W-1:0]    q_addr,
    input  logic                 q_full
);

    localparam int IDX_W = $clog2(GRID_SIZE);
    localparam int POS_W = FRAC_W + IDX_W;
    localparam int CMP_W = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
    localparam int CELLS = GRID_SIZE * GRID_SIZE;

    logic                adv;
    logic                keep;
    esb_cmd_t            cmd;
    logic [CMP_W-1:0]    idx_ext;

    logic                f1_valid_reg;
    esb_cmd_t            f1_op_reg;
    logic [ELEV_W-1:0]   f1_wdata_reg;
    logic [ADDR_W-1:0]   f1_load_addr_reg;
    logic [POS_W-1:0]    f1_lat_pos_reg;
    logic [POS_W-1:0]    f1_lon_pos_reg;

    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    col;
    logic [ADDR_W-1:0]   row_off;

    logic                f2_valid_reg;
    esb_cmd_t            f2_op_reg;
    logic [ELEV_W-1:0]   f2_wdata_reg;
    logic [ADDR_W-1:0]   f2_base_reg;
    logic [IDX_W-1:0]    f2_col_reg;
    logic [FRAC_W-1:0]   f2_dy_reg;
    logic [FRAC_W-1:0]   f2_dx_reg;

    logic                f3_valid_reg;
    esb_job_t            f3_job_reg;
    logic [ADDR_W-1:0]   f3_addr_reg;

    // whole front moves together; it only holds when the last stage cannot push
    assign adv     = !f3_valid_reg || !q_full;
    assign s_ready = adv;

    assign cmd     = esb_cmd_t'(s_cmd);
    assign idx_ext = CMP_W'(s_sample_index);

    always_comb begin
        case (cmd)
            CMD_LOAD:     keep = (idx_ext < CMP_W'(CELLS));
            CMD_NEAREST:  keep = 1'b1;
            CMD_BILINEAR: keep = 1'b1;
            default:      keep = 1'b0;
        endcase
    end

    // row counted from the south; stored rows run from the north
    assign row     = f1_lat_pos_reg[POS_W-1:FRAC_W];
    assign col     = f1_lon_pos_reg[POS_W-1:FRAC_W];
    assign row_off = ADDR_W'(IDX_W'(GRID_SIZE - 1) - row) * ADDR_W'(GRID_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end else if (adv) begin
            f1_valid_reg <= s_valid && keep;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_op_reg        <= cmd;
            f1_wdata_reg     <= {s_sample_high_byte, s_sample_low_byte};
            f1_load_addr_reg <= idx_ext[ADDR_W-1:0];
            f1_lat_pos_reg   <= POS_W'(s_lat_fraction) * POS_W'(GRID_SIZE - 1);
            f1_lon_pos_reg   <= POS_W'(s_lon_fraction) * POS_W'(GRID_SIZE - 1);

            f2_op_reg    <= f1_op_reg;
            f2_wdata_reg <= f1_wdata_reg;
            f2_dy_reg    <= f1_lat_pos_reg[FRAC_W-1:0];
            f2_dx_reg    <= f1_lon_pos_reg[FRAC_W-1:0];
            if (f1_op_reg == CMD_LOAD) begin
                f2_base_reg <= f1_load_addr_reg;
                f2_col_reg  <= '0;
            end else begin
                f2_base_reg <= row_off;
                f2_col_reg  <= col;
            end

            f3_job_reg.op    <= f2_op_reg;
            f3_job_reg.wdata <= f2_wdata_reg;
            f3_job_reg.dy    <= f2_dy_reg;
            f3_job_reg.dx    <= f2_dx_reg;
            f3_addr_reg      <= f2_base_reg + ADDR_W'(f2_col_reg);
        end
    end

    assign q_push = f3_valid_reg && !q_full;
    assign q_job  = f3_job_reg;
    assign q_addr = f3_addr_reg;

endmodule

// File: rtl/core/esb_queue.sv
`timescale 1ns / 1ps

module esb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PTR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [WIDTH-1:0]  push_data,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output logic [WIDTH-1:0]  head_data
);

    logic [WIDTH-1:0]  slot_reg [DEPTH];
    logic [PTR_W-1:0]  wptr_reg;
    logic [PTR_W-1:0]  rptr_reg;
    logic [PTR_W:0]    count_reg;
    logic [PTR_W:0]    count_next;

    assign full       = (count_reg == (PTR_W + 1)'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push)
            slot_reg[wptr_reg] <= push_data;
    end

endmodule

// File: rtl/core/esb_back.sv
`timescale 1ns / 1ps

module esb_back import esb_pkg::*; #(
    parameter int GRID_SIZE = 1201,
    localparam int ADDR_W = $clog2(GRID_SIZE * GRID_SIZE)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    input  esb_job_t                  q_job,
    input  logic [ADDR_W-1:0]         q_addr,
    output logic                      q_pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [ELEV_W-1:0]  m_elevation
);

    localparam int CELLS  = GRID_SIZE * GRID_SIZE;
    localparam int A_W    = ELEV_W + W_W;
    localparam int AH_W   = A_W - FRAC_W;
    localparam int PAH_W  = AH_W + W_W;
    localparam int PAL_W  = FRAC_W + W_W;
    localparam int P_W    = PAH_W + 2;
    localparam int R_W    = PAL_W + 2;
    localparam int U_W    = P_W + 1;
    localparam int Q_W    = U_W - FRAC_W;
    localparam int OPTR_W = $clog2(OUT_DEPTH);

    esb_phase_t          state_reg;
    esb_phase_t          state_next;

    logic                credit_ok;
    logic                start_bilinear;
    logic                alloc;
    logic                we;
    logic                rd_en;
    logic [ADDR_W-1:0]   mem_addr;
    logic [W_W-1:0]      wx;
    logic [W_W-1:0]      wy;
    logic                first;
    logic                last;

    logic [ELEV_W-1:0]   grid_mem [CELLS];
    logic [ELEV_W-1:0]   rdata_reg;

    logic                v0_reg;
    logic                first0_reg;
    logic                last0_reg;
    logic [W_W-1:0]      wx0_reg;
    logic [W_W-1:0]      wy0_reg;

    logic signed [A_W-1:0]   h_ext;
    logic signed [A_W-1:0]   wx_ext;
    logic                    v1_reg;
    logic                    first1_reg;
    logic                    last1_reg;
    logic [W_W-1:0]          wy1_reg;
    logic signed [A_W-1:0]   a1_reg;

    logic signed [AH_W-1:0]  ah;
    logic signed [PAH_W-1:0] ah_ext;
    logic signed [PAH_W-1:0] wy_ext;
    logic                    v2_reg;
    logic                    first2_reg;
    logic                    last2_reg;
    logic signed [PAH_W-1:0] pah2_reg;
    logic [PAL_W-1:0]        pal2_reg;

    logic                    done3_reg;
    logic signed [P_W-1:0]   acc_p_reg;
    logic [R_W-1:0]          acc_r_reg;

    logic signed [U_W-1:0]   r_hi_ext;
    logic                    v4_reg;
    logic signed [U_W-1:0]   u4_reg;
    logic                    inexact4_reg;

    logic signed [Q_W-1:0]   q_floor;
    logic signed [Q_W-1:0]   q_trunc;
    logic                    bump;

    logic [ELEV_W-1:0]   out_mem_reg [OUT_DEPTH];
    logic [OPTR_W-1:0]   owptr_reg;
    logic [OPTR_W-1:0]   orptr_reg;
    logic [OPTR_W:0]     ocount_reg;
    logic [OPTR_W:0]     credit_reg;
    logic                out_take;

    // every query holds an output slot from its first read until it leaves
    assign credit_ok = (credit_reg < (OPTR_W + 1)'(OUT_DEPTH));
    assign out_take  = m_valid && m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            PH_READ00: if (start_bilinear) state_next = PH_READ01;
            PH_READ01: state_next = PH_READ10;
            PH_READ10: state_next = PH_READ11;
            PH_READ11: state_next = PH_READ00;
            default:   state_next = PH_READ00;
        endcase
    end

    always_comb begin
        q_pop          = 1'b0;
        we             = 1'b0;
        rd_en          = 1'b0;
        alloc          = 1'b0;
        start_bilinear = 1'b0;
        first          = 1'b0;
        last           = 1'b0;
        mem_addr       = q_addr;
        wx             = W_ONE;
        wy             = W_ONE;
        case (state_reg)
            PH_READ00: begin
                if (q_valid) begin
                    case (q_job.op)
                        CMD_LOAD: begin
                            we    = 1'b1;
                            q_pop = 1'b1;
                        end
                        CMD_NEAREST: begin
                            if (credit_ok) begin
                                rd_en = 1'b1;
                                alloc = 1'b1;
                                q_pop = 1'b1;
                                first = 1'b1;
                                last  = 1'b1;
                            end
                        end
                        CMD_BILINEAR: begin
                            if (credit_ok) begin
                                rd_en          = 1'b1;
                                alloc          = 1'b1;
                                start_bilinear = 1'b1;
                                first          = 1'b1;
                                wx             = W_ONE - W_W'(q_job.dx);
                                wy             = W_ONE - W_W'(q_job.dy);
                            end
                        end
                        default: q_pop = 1'b1;
                    endcase
                end
            end
            PH_READ01: begin
                rd_en    = 1'b1;
                mem_addr = q_addr + ADDR_W'(1);
                wx       = W_W'(q_job.dx);
                wy       = W_ONE - W_W'(q_job.dy);
            end
            PH_READ10: begin
                rd_en    = 1'b1;
                mem_addr = q_addr - ADDR_W'(GRID_SIZE);
                wx       = W_ONE - W_W'(q_job.dx);
                wy       = W_W'(q_job.dy);
            end
            PH_READ11: begin
                rd_en    = 1'b1;
                q_pop    = 1'b1;
                last     = 1'b1;
                mem_addr = q_addr - ADDR_W'(GRID_SIZE - 1);
                wx       = W_W'(q_job.dx);
                wy       = W_W'(q_job.dy);
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we)
            grid_mem[mem_addr] <= q_job.wdata;
        if (rd_en)
            rdata_reg <= grid_mem[mem_addr];
    end

    // weighted sum kept exact: a = h*wx split as ah*S + al, each part times wy
    assign h_ext    = A_W'($signed(rdata_reg));
    assign wx_ext   = A_W'(wx0_reg);
    assign ah       = a1_reg[A_W-1:FRAC_W];
    assign ah_ext   = PAH_W'(ah);
    assign wy_ext   = PAH_W'(wy1_reg);
    assign r_hi_ext = U_W'(acc_r_reg[R_W-1:FRAC_W]);

    // floor, then back one step towards zero when negative and inexact
    assign q_floor = u4_reg[U_W-1:FRAC_W];
    assign bump    = q_floor[Q_W-1] && (inexact4_reg || (u4_reg[FRAC_W-1:0] != '0));
    assign q_trunc = q_floor + Q_W'(bump);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= PH_READ00;
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            done3_reg <= 1'b0;
            v4_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            v0_reg    <= rd_en;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            done3_reg <= v2_reg && last2_reg;
            v4_reg    <= done3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        first0_reg <= first;
        last0_reg  <= last;
        wx0_reg    <= wx;
        wy0_reg    <= wy;

        first1_reg <= first0_reg;
        last1_reg  <= last0_reg;
        wy1_reg    <= wy0_reg;
        a1_reg     <= h_ext * wx_ext;

        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        pah2_reg   <= ah_ext * wy_ext;
        pal2_reg   <= PAL_W'(a1_reg[FRAC_W-1:0]) * PAL_W'(wy1_reg);

        if (v2_reg) begin
            if (first2_reg) begin
                acc_p_reg <= P_W'(pah2_reg);
                acc_r_reg <= R_W'(pal2_reg);
            end else begin
                acc_p_reg <= acc_p_reg + P_W'(pah2_reg);
                acc_r_reg <= acc_r_reg + R_W'(pal2_reg);
            end
        end

        u4_reg       <= U_W'(acc_p_reg) + r_hi_ext;
        inexact4_reg <= (acc_r_reg[FRAC_W-1:0] != '0);
    end

    // result buffer; credits keep it from overflowing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owptr_reg  <= '0;
            orptr_reg  <= '0;
            ocount_reg <= '0;
            credit_reg <= '0;
        end else begin
            if (v4_reg)
                owptr_reg <= owptr_reg + 1'b1;
            if (out_take)
                orptr_reg <= orptr_reg + 1'b1;
            if (v4_reg && !out_take)
                ocount_reg <= ocount_reg + 1'b1;
            else if (out_take && !v4_reg)
                ocount_reg <= ocount_reg - 1'b1;
            if (alloc && !out_take)
                credit_reg <= credit_reg + 1'b1;
            else if (out_take && !alloc)
                credit_reg <= credit_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (v4_reg)
            out_mem_reg[owptr_reg] <= q_trunc[ELEV_W-1:0];
    end

    assign m_valid     = (ocount_reg != '0);
    assign m_elevation = out_mem_reg[orptr_reg];

endmodule

// File: rtl/core/elevation_grid_bilinear_sampler_core.sv
`timescale 1ns / 1ps
// Channel   Ports                                              Direction
// input     s_valid s_ready s_cmd s_sample_index               in
//           s_sample_high_byte s_sample_low_byte
//           s_lat_fraction s_lon_fraction
// result    m_valid m_ready m_elevation                        out
//
// A load writes the grid memory once, a nearest query reads it once and a
// bilinear query four times, since the memory has a single read port. Items
// enter every cycle while the job queue has room; with nothing queued ahead, a
// query passes the front stages, job queue, memory read, multiply stages,
// accumulator and rounding stage before m_valid rises. Up to eight results may
// wait on m_ready before queries stall. Reset clears control only: the grid is
// not cleared, and an entry must be loaded before it is queried.

module elevation_grid_bilinear_sampler_core import esb_pkg::*; #(
    parameter int GRID_SIZE = 1201
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [CMD_W-1:0]          s_cmd,
    input  logic [INDEX_W-1:0]        s_sample_index,
    input  logic [BYTE_W-1:0]         s_sample_high_byte,
    input  logic [BYTE_W-1:0]         s_sample_low_byte,
    input  logic [FRAC_W-1:0]         s_lat_fraction,
    input  logic [FRAC_W-1:0]         s_lon_fraction,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [ELEV_W-1:0]  m_elevation
);

    localparam int ADDR_W = $clog2(GRID_SIZE * GRID_SIZE);
    localparam int QW     = $bits(esb_job_t) + ADDR_W;

    logic               push;
    logic               full;
    logic               pop;
    logic               head_valid;
    esb_job_t           f_job;
    logic [ADDR_W-1:0]  f_addr;
    esb_job_t           h_job;
    logic [ADDR_W-1:0]  h_addr;
    logic [QW-1:0]      push_data;
    logic [QW-1:0]      head_data;

    assign push_data       = {f_job, f_addr};
    assign {h_job, h_addr} = head_data;

    esb_front #(
        .GRID_SIZE (GRID_SIZE)
    ) u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_sample_index     (s_sample_index),
        .s_sample_high_byte (s_sample_high_byte),
        .s_sample_low_byte  (s_sample_low_byte),
        .s_lat_fraction     (s_lat_fraction),
        .s_lon_fraction     (s_lon_fraction),
        .q_push             (push),
        .q_job              (f_job),
        .q_addr             (f_addr),
        .q_full             (full)
    );

    esb_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    esb_back #(
        .GRID_SIZE (GRID_SIZE)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (head_valid),
        .q_job       (h_job),
        .q_addr      (h_addr),
        .q_pop       (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_elevation (m_elevation)
    );

endmodule
